// File: rtl/slad_pkg.sv
// Shared types, codes and constants for the status LED animator.
// Holds the raised-cosine pulse table built at elaboration; no dependencies.
package slad_pkg;

    // Phase resolution of the charging pulse.
    localparam int PHASE_BITS = 8;
    localparam int PHASE_SPAN = 1 << PHASE_BITS;

    // Age counter in microseconds, kept modulo one second.
    localparam int AGE_W     = 20;
    localparam int AGE_SUM_W = AGE_W + 1;
    localparam logic [AGE_W-1:0]     ONE_SECOND_US  = 20'd1000000;
    localparam logic [AGE_SUM_W-1:0] TWO_SECONDS_US = 21'd2000000;
    localparam logic [AGE_W-1:0]     HALF_PERIOD_US = 20'd250000;
    localparam logic [AGE_W-1:0]     FULL_PERIOD_US = 20'd500000;
    localparam logic [AGE_W-1:0]     THREE_HALF_US  = 20'd750000;

    // Reciprocal of one second for the phase: phase = (age * RECIP) >> RECIP_SHIFT.
    // The shift is wide enough that the rounded-up reciprocal gives the exact floor.
    localparam int RECIP_SHIFT = 40;
    localparam int RECIP_W     = PHASE_BITS + 21;
    localparam int PROD_W      = AGE_W + RECIP_W;
    localparam logic [RECIP_W-1:0] PHASE_RECIP =
        RECIP_W'(((64'd1 << (PHASE_BITS + RECIP_SHIFT)) + 64'd999999) / 64'd1000000);

    // Q30 constants for the table generator.
    localparam logic [63:0] Q30_ONE = 64'd1073741824;
    localparam logic [63:0] PI_Q30  = 64'd3373259426;

    // Request kinds.
    localparam logic [1:0] MODE_TICK       = 2'd0;
    localparam logic [1:0] MODE_SET_STATE  = 2'd1;
    localparam logic [1:0] MODE_SET_COLOUR = 2'd2;

    // Animation states.
    localparam logic [2:0] ST_OFF      = 3'd0;
    localparam logic [2:0] ST_IDLE     = 3'd1;
    localparam logic [2:0] ST_CHARGING = 3'd2;
    localparam logic [2:0] ST_CHARGED  = 3'd3;
    localparam logic [2:0] ST_ALERT    = 3'd4;

    // Fixed colour levels.
    localparam logic [7:0] LEVEL_DIM    = 8'h40;
    localparam logic [7:0] LEVEL_STEADY = 8'hC0;
    localparam logic [7:0] LEVEL_FULL   = 8'hFF;

    typedef struct packed {
        logic [1:0]       mode;
        logic [AGE_W-1:0] elapsed_us;
        logic [2:0]       new_state;
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
    } item_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } colour_t;

    typedef struct packed {
        colour_t    colour;
        logic [2:0] state;
    } result_t;

    typedef logic [7:0] pulse_lut_t [PHASE_SPAN];

    // Blue level at one phase: sin^2 of the folded angle by a Taylor series in Q30.
    function automatic logic [7:0] pulse_level(input int unsigned idx);
        logic [63:0] span;
        logic [63:0] p;
        logic [63:0] a;
        logic [63:0] a2;
        logic [63:0] t;
        logic [63:0] sn;
        logic [63:0] s;
        logic [63:0] v;
        span = 64'd1 << PHASE_BITS;
        p    = 64'(idx);
        if (p > span - p)
        begin
            p = span - p;
        end
        a  = (PI_Q30 * p) >> PHASE_BITS;
        a2 = (a * a) >> 30;
        t  = Q30_ONE - a2 / 64'd72;
        t  = Q30_ONE - ((a2 * t) >> 30) / 64'd42;
        t  = Q30_ONE - ((a2 * t) >> 30) / 64'd20;
        t  = Q30_ONE - ((a2 * t) >> 30) / 64'd6;
        sn = (a * t) >> 30;
        s  = (sn * sn) >> 30;
        v  = (s * 64'd255) >> 30;
        return (v > 64'd255) ? 8'hFF : v[7:0];
    endfunction

    function automatic pulse_lut_t build_pulse_lut();
        pulse_lut_t lut;
        for (int i = 0; i < PHASE_SPAN; i++)
        begin
            lut[i] = pulse_level(i);
        end
        return lut;
    endfunction

    localparam pulse_lut_t PULSE_LUT = build_pulse_lut();

endpackage

// File: rtl/slad_colour.sv
// Animation colour for a given state and age.
// Uses slad_pkg for the pulse table, phase reciprocal and state codes.
module slad_colour (
    input  logic [2:0]                state,
    input  logic [slad_pkg::AGE_W-1:0] age,
    output slad_pkg::colour_t         colour
);
    import slad_pkg::*;

    logic [PROD_W-1:0]     phase_prod;
    logic [PHASE_BITS-1:0] phase;
    logic                  odd_quarter;

    // Phase of the one-second pulse: the floor of age * 2^PHASE_BITS / 1e6.
    assign phase_prod = PROD_W'(age) * PROD_W'(PHASE_RECIP);
    assign phase      = phase_prod[RECIP_SHIFT +: PHASE_BITS];

    // The alert wave is dark in the second and fourth quarter second.
    assign odd_quarter = (age >= HALF_PERIOD_US) ^ (age >= FULL_PERIOD_US)
                       ^ (age >= THREE_HALF_US);

    // Colour per animation state.
    always_comb
    begin
        colour = '0;
        case (state)
            ST_IDLE:
            begin
                colour.red   = LEVEL_DIM;
                colour.green = LEVEL_DIM;
                colour.blue  = LEVEL_DIM;
            end
            ST_CHARGING:
            begin
                colour.blue = PULSE_LUT[phase];
            end
            ST_CHARGED:
            begin
                colour.green = LEVEL_STEADY;
            end
            ST_ALERT:
            begin
                colour.red = odd_quarter ? 8'h00 : LEVEL_FULL;
            end
            default:
            begin
                colour = '0;
            end
        endcase
    end

endmodule

// File: rtl/slad_outreg.sv
// Result register that faces the output channel.
// Uses slad_pkg for the result type.
module slad_outreg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  slad_pkg::result_t load_data,
    output logic              load_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output slad_pkg::result_t out_data
);
    import slad_pkg::*;

    logic    valid_reg;
    result_t data_reg;

    // A new result may enter when the register is empty or is being drained.
    assign load_ready = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign out_data   = data_reg;

    // Valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

endmodule

// File: rtl/slad_core.sv
// Input register, animation state and per-request update logic.
// Uses slad_pkg and instantiates slad_colour.
module slad_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  slad_pkg::item_t   item,
    input  logic              load_ready,
    output logic              load,
    output slad_pkg::result_t result
);
    import slad_pkg::*;

    logic                 item_valid_reg;
    item_t                item_reg;
    logic [2:0]           anim_state_reg;
    logic [2:0]           anim_state_next;
    logic                 override_reg;
    logic                 override_next;
    logic [AGE_W-1:0]     age_reg;
    logic [AGE_W-1:0]     age_next;
    logic [AGE_SUM_W-1:0] age_sum;
    logic [AGE_W-1:0]     age_wrapped;
    logic                 advance;
    logic                 has_result;
    logic [2:0]           eval_state;
    logic [AGE_W-1:0]     eval_age;
    colour_t              anim_colour;

    // The held request moves on once the result register can take its result.
    assign advance  = item_valid_reg && load_ready;
    assign in_ready = !item_valid_reg || load_ready;
    assign load     = advance && has_result;

    // Advance the age and wrap it into one second; at most two wraps are needed.
    assign age_sum = AGE_SUM_W'(age_reg) + AGE_SUM_W'(item_reg.elapsed_us);
    always_comb
    begin
        if (age_sum >= TWO_SECONDS_US)
        begin
            age_wrapped = AGE_W'(age_sum - TWO_SECONDS_US);
        end
        else if (age_sum >= AGE_SUM_W'(ONE_SECOND_US))
        begin
            age_wrapped = AGE_W'(age_sum - AGE_SUM_W'(ONE_SECOND_US));
        end
        else
        begin
            age_wrapped = age_sum[AGE_W-1:0];
        end
    end

    // Next state and result for the held request.
    always_comb
    begin
        anim_state_next = anim_state_reg;
        override_next   = override_reg;
        age_next        = age_reg;
        has_result      = 1'b0;
        eval_state      = anim_state_reg;
        eval_age        = age_wrapped;
        case (item_reg.mode)
            MODE_TICK:
            begin
                age_next   = age_wrapped;
                has_result = !override_reg;
            end
            MODE_SET_STATE:
            begin
                if (item_reg.new_state <= ST_ALERT)
                begin
                    anim_state_next = item_reg.new_state;
                    override_next   = 1'b0;
                    age_next        = '0;
                    has_result      = 1'b1;
                    eval_state      = item_reg.new_state;
                    eval_age        = '0;
                end
            end
            MODE_SET_COLOUR:
            begin
                override_next = 1'b1;
                has_result    = 1'b1;
            end
            default:
            begin
                has_result = 1'b0;
            end
        endcase
    end

    slad_colour u_colour (
        .state  (eval_state),
        .age    (eval_age),
        .colour (anim_colour)
    );

    // A colour request passes its own colour; the others take the animation.
    always_comb
    begin
        result.state = anim_state_next;
        if (item_reg.mode == MODE_SET_COLOUR)
        begin
            result.colour.red   = item_reg.red;
            result.colour.green = item_reg.green;
            result.colour.blue  = item_reg.blue;
        end
        else
        begin
            result.colour = anim_colour;
        end
    end

    // Control and animation state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            anim_state_reg <= ST_OFF;
            override_reg   <= 1'b0;
            age_reg        <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                item_valid_reg <= in_valid;
            end
            if (advance)
            begin
                anim_state_reg <= anim_state_next;
                override_reg   <= override_next;
                age_reg        <= age_next;
            end
        end
    end

    // Held request payload.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= item;
        end
    end

    // The age never reaches one second.
    a_age_range: assert property (@(posedge clk) disable iff (!rst_n)
        age_reg < ONE_SECOND_US)
        else $error("age counter out of range");

    // Only defined animation states are ever held.
    a_state_range: assert property (@(posedge clk) disable iff (!rst_n)
        anim_state_reg <= ST_ALERT)
        else $error("animation state out of range");

    // A colour request turns on manual override.
    a_override_set: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && item_reg.mode == MODE_SET_COLOUR) |=> override_reg)
        else $error("override not set after colour request");

    // A valid state request restarts the age and ends override.
    a_state_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && item_reg.mode == MODE_SET_STATE && item_reg.new_state <= ST_ALERT)
        |=> (age_reg == '0 && !override_reg))
        else $error("state request did not restart the animation");

endmodule

// File: rtl/status_led_animator.sv
// Status LED animator: takes requests (tick, state change or manual colour) and
// returns the LED colour each one causes. An accepted request is held in the input
// register, where a single pass through the age update, one multiply for the pulse
// phase and a table lookup feeds the result register. With out_ready held high the
// block sustains one request per cycle; a full result register that is not being
// drained stalls in_ready.
// Ticks under manual override, unused modes and unknown states give no result.
module status_led_animator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  mode,
    input  logic [19:0] elapsed_us,
    input  logic [2:0]  new_state,
    input  logic [7:0]  red_in,
    input  logic [7:0]  green_in,
    input  logic [7:0]  blue_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  red_out,
    output logic [7:0]  green_out,
    output logic [7:0]  blue_out,
    output logic [2:0]  current_state
);
    import slad_pkg::*;

    item_t   item;
    result_t core_result;
    result_t out_data;
    logic    load;
    logic    load_ready;

    // Gather the request fields.
    assign item.mode       = mode;
    assign item.elapsed_us = elapsed_us;
    assign item.new_state  = new_state;
    assign item.red        = red_in;
    assign item.green      = green_in;
    assign item.blue       = blue_in;

    slad_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .item       (item),
        .load_ready (load_ready),
        .load       (load),
        .result     (core_result)
    );

    slad_outreg u_outreg (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (load),
        .load_data  (core_result),
        .load_ready (load_ready),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

    // Split the result onto the output ports.
    assign red_out       = out_data.colour.red;
    assign green_out     = out_data.colour.green;
    assign blue_out      = out_data.colour.blue;
    assign current_state = out_data.state;

endmodule

// File: test/tb_status_led_animator.sv
`timescale 1ns / 1ps
// Testbench for status_led_animator: tick, state and colour requests with random idling
// on both handshakes, every LED frame checked against an in-bench colour predictor.
// Depends on slad_pkg and the status_led_animator RTL.
module tb_status_led_animator;
    import slad_pkg::*;

    // The block ignores this request kind entirely.
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int RANDOM_REQUESTS = 1100;
    localparam int CYCLE_LIMIT = 600000;

    // Tracks the animator state and the LED frames it still owes.
    class led_frame_tracker;
        logic [2:0]  anim;
        bit          override;
        logic [19:0] age;
        result_t     frames_due[$];
        int          fails;

        function new();
            anim = ST_OFF;
            override = 1'b0;
            age = '0;
            fails = 0;
        endfunction

        // Raised-cosine blue level: sin^2 of the folded phase angle, Q30 Taylor series.
        function logic [7:0] pulse_blue(logic [19:0] age_us);
            logic [63:0] span;
            logic [63:0] phase;
            logic [63:0] fold;
            logic [63:0] ang;
            logic [63:0] ang2;
            logic [63:0] poly;
            logic [63:0] sn;
            logic [63:0] sq;
            logic [63:0] lvl;
            span = 64'd1 << PHASE_BITS;
            phase = (64'(age_us) << PHASE_BITS) / 64'(ONE_SECOND_US);
            if (phase >= span)
            begin
                phase = span - 64'd1;
            end
            fold = (phase > span - phase) ? (span - phase) : phase;
            ang  = (PI_Q30 * fold) >> PHASE_BITS;
            ang2 = (ang * ang) >> 30;
            poly = Q30_ONE - ang2 / 64'd72;
            poly = Q30_ONE - ((ang2 * poly) >> 30) / 64'd42;
            poly = Q30_ONE - ((ang2 * poly) >> 30) / 64'd20;
            poly = Q30_ONE - ((ang2 * poly) >> 30) / 64'd6;
            sn   = (ang * poly) >> 30;
            sq   = (sn * sn) >> 30;
            lvl  = (sq * 64'd255) >> 30;
            return (lvl > 64'd255) ? 8'hFF : lvl[7:0];
        endfunction

        // Colour that the current animation shows at the current age.
        function colour_t animation_colour();
            colour_t c;
            c = '0;
            case (anim)
                ST_IDLE:
                begin
                    c.red = LEVEL_DIM;
                    c.green = LEVEL_DIM;
                    c.blue = LEVEL_DIM;
                end
                ST_CHARGING: c.blue = pulse_blue(age);
                ST_CHARGED:  c.green = LEVEL_STEADY;
                ST_ALERT:    c.red = ((age / HALF_PERIOD_US) % 2 == 0) ? LEVEL_FULL : 8'h00;
                default:     c = '0;
            endcase
            return c;
        endfunction

        // Applies one accepted request and queues the frame it causes, if any.
        function void note_request(item_t rq);
            result_t     frame;
            logic [20:0] sum;
            case (rq.mode)
                MODE_TICK:
                begin
                    sum = 21'(age) + 21'(rq.elapsed_us);
                    while (sum >= 21'(ONE_SECOND_US))
                    begin
                        sum = sum - 21'(ONE_SECOND_US);
                    end
                    age = sum[19:0];
                    if (override)
                    begin
                        return;
                    end
                    frame.colour = animation_colour();
                end
                MODE_SET_STATE:
                begin
                    if (rq.new_state > ST_ALERT)
                    begin
                        return;
                    end
                    anim = rq.new_state;
                    age = '0;
                    override = 1'b0;
                    frame.colour = animation_colour();
                end
                MODE_SET_COLOUR:
                begin
                    override = 1'b1;
                    frame.colour = {rq.red, rq.green, rq.blue};
                end
                default: return;
            endcase
            frame.state = anim;
            frames_due.push_back(frame);
        endfunction

        // Compares one delivered frame with the oldest one owed.
        function void check_frame(result_t got);
            result_t want;
            if (frames_due.size() == 0)
            begin
                $error("unexpected LED frame: red %0d green %0d blue %0d state %0d",
                       got.colour.red, got.colour.green, got.colour.blue, got.state);
                fails++;
                return;
            end
            want = frames_due.pop_front();
            if (got.colour.red !== want.colour.red)
            begin
                $error("red_out: expected %0d, got %0d", want.colour.red, got.colour.red);
                fails++;
            end
            if (got.colour.green !== want.colour.green)
            begin
                $error("green_out: expected %0d, got %0d", want.colour.green, got.colour.green);
                fails++;
            end
            if (got.colour.blue !== want.colour.blue)
            begin
                $error("blue_out: expected %0d, got %0d", want.colour.blue, got.colour.blue);
                fails++;
            end
            if (got.state !== want.state)
            begin
                $error("current_state: expected %0d, got %0d", want.state, got.state);
                fails++;
            end
        endfunction

        function int pending();
            return frames_due.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  mode;
    logic [19:0] elapsed_us;
    logic [2:0]  new_state;
    logic [7:0]  red_in;
    logic [7:0]  green_in;
    logic [7:0]  blue_in;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  red_out;
    logic [7:0]  green_out;
    logic [7:0]  blue_out;
    logic [2:0]  current_state;

    led_frame_tracker board = new();
    bit no_idle = 1'b0;
    int cycle_count = 0;

    status_led_animator dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .mode          (mode),
        .elapsed_us    (elapsed_us),
        .new_state     (new_state),
        .red_in        (red_in),
        .green_in      (green_in),
        .blue_in       (blue_in),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .red_out       (red_out),
        .green_out     (green_out),
        .blue_out      (blue_out),
        .current_state (current_state)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard stop in case a handshake never completes.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Idle cycles before the next request or frame; none during burst stretches.
    function automatic int idle_cycles();
        return no_idle ? 0 : $urandom_range(0, 17);
    endfunction

    function automatic item_t make_request(logic [1:0] m, logic [19:0] us, logic [2:0] st,
                                           logic [7:0] r, logic [7:0] g, logic [7:0] b);
        item_t rq;
        rq.mode = m;
        rq.elapsed_us = us;
        rq.new_state = st;
        rq.red = r;
        rq.green = g;
        rq.blue = b;
        return rq;
    endfunction

    // Mostly ticks inside animations, with state changes, manual colours and noise.
    function automatic item_t random_request();
        item_t rq;
        int    pick;
        int    span_pick;
        rq.new_state = 3'($urandom);
        rq.red = 8'($urandom);
        rq.green = 8'($urandom);
        rq.blue = 8'($urandom);
        span_pick = $urandom_range(0, 9);
        if (span_pick < 4)
            rq.elapsed_us = 20'd50000;
        else if (span_pick < 7)
            rq.elapsed_us = 20'($urandom_range(0, 999999));
        else if (span_pick == 7)
            rq.elapsed_us = 20'($urandom);
        else if (span_pick == 8)
            rq.elapsed_us = 20'($urandom_range(0, 5000));
        else
            rq.elapsed_us = 20'(250000 * $urandom_range(1, 3) + $urandom_range(0, 2) - 1);

        pick = $urandom_range(0, 99);
        if (pick < 70)
        begin
            rq.mode = MODE_TICK;
        end
        else if (pick < 84)
        begin
            rq.mode = MODE_SET_STATE;
            if (pick >= 82)
            begin
                rq.new_state = 3'($urandom_range(5, 7));
            end
            else
            begin
                case ($urandom_range(0, 6))
                    0:       rq.new_state = ST_OFF;
                    1:       rq.new_state = ST_IDLE;
                    2, 3:    rq.new_state = ST_CHARGING;
                    4:       rq.new_state = ST_CHARGED;
                    default: rq.new_state = ST_ALERT;
                endcase
            end
        end
        else if (pick < 94)
        begin
            rq.mode = MODE_SET_COLOUR;
        end
        else
        begin
            rq.mode = MODE_UNUSED;
        end
        return rq;
    endfunction

    // Presents one request after a random gap and holds it until it is taken.
    task automatic push_request(input item_t rq);
        int gap;
        bit ready_seen;
        gap = idle_cycles();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        mode       <= rq.mode;
        elapsed_us <= rq.elapsed_us;
        new_state  <= rq.new_state;
        red_in     <= rq.red;
        green_in   <= rq.green;
        blue_in    <= rq.blue;
        do
        begin
            @(negedge clk);
            ready_seen = (in_ready === 1'b1);
            @(posedge clk);
        end
        while (!ready_seen);
        board.note_request(rq);
    endtask

    // Waits until every owed frame has been delivered; the request line is already low.
    task automatic wait_frames_drained();
        while (board.pending() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Frame consumer with a random stall before each frame.
    initial
    begin
        int stall;
        bit took;
        out_ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            stall = idle_cycles();
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
            begin
                @(negedge clk);
                took = (out_valid === 1'b1);
                @(posedge clk);
            end
            while (!took);
        end
    end

    // Samples frames between edges and checks each one taken at the next edge.
    always
    begin : frame_monitor
        result_t frame;
        bit      hit;
        @(negedge clk);
        hit = (out_valid === 1'b1) && (out_ready === 1'b1);
        frame.colour.red = red_out;
        frame.colour.green = green_out;
        frame.colour.blue = blue_out;
        frame.state = current_state;
        @(posedge clk);
        if (hit)
        begin
            board.check_frame(frame);
        end
    end

    initial
    begin
        item_t rq;
        int    counted;
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        mode       <= MODE_TICK;
        elapsed_us <= '0;
        new_state  <= ST_OFF;
        red_in     <= '0;
        green_in   <= '0;
        blue_in    <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed requests: reset colour, each animation, pulse and alert edges, override.
        push_request(make_request(MODE_TICK, 20'd0, ST_OFF, 8'h00, 8'h00, 8'h00));
        push_request(make_request(MODE_SET_STATE, 20'hFFFFF, ST_IDLE, 8'hFF, 8'hFF, 8'hFF));
        push_request(make_request(MODE_TICK, 20'hFFFFF, ST_ALERT, 8'h00, 8'h00, 8'h00));
        push_request(make_request(MODE_SET_STATE, 20'd0, ST_CHARGED, 8'h00, 8'h00, 8'h00));
        push_request(make_request(MODE_SET_STATE, 20'd0, ST_CHARGING, 8'h00, 8'h00, 8'h00));
        push_request(make_request(MODE_TICK, 20'd250000, ST_OFF, 8'h00, 8'h00, 8'h00));
        push_request(make_request(MODE_TICK, 20'd250000, ST_OFF, 8'h00, 8'h00, 8'h00));
        push_request(make_request(MODE_TICK, 20'd1953, ST_OFF, 8'h00, 8'h00, 8'h00));
        push_request(make_request(MODE_TICK, 20'd498046, ST_OFF, 8'h00, 8'h00, 8'h00));
        push_request(make_request(MODE_TICK, 20'd1, ST_OFF, 8'h00, 8'h00, 8'h00));
        push_request(make_request(MODE_SET_STATE, 20'd0, ST_ALERT, 8'h00, 8'h00, 8'h00));
        push_request(make_request(MODE_TICK, 20'd249999, ST_OFF, 8'h00, 8'h00, 8'h00));
        push_request(make_request(MODE_TICK, 20'd1, ST_OFF, 8'h00, 8'h00, 8'h00));
        push_request(make_request(MODE_TICK, 20'd250000, ST_OFF, 8'h00, 8'h00, 8'h00));
        push_request(make_request(MODE_TICK, 20'd250000, ST_OFF, 8'h00, 8'h00, 8'h00));
        push_request(make_request(MODE_SET_COLOUR, 20'd0, ST_OFF, 8'hFF, 8'hFF, 8'hFF));
        push_request(make_request(MODE_TICK, 20'd50000, ST_OFF, 8'h00, 8'h00, 8'h00));
        push_request(make_request(MODE_SET_COLOUR, 20'hFFFFF, 3'd7, 8'h00, 8'h00, 8'h00));
        push_request(make_request(MODE_UNUSED, 20'hFFFFF, 3'd7, 8'hFF, 8'hFF, 8'hFF));
        push_request(make_request(MODE_SET_STATE, 20'd0, 3'd5, 8'h00, 8'h00, 8'h00));
        push_request(make_request(MODE_SET_STATE, 20'd0, 3'd6, 8'h00, 8'h00, 8'h00));
        push_request(make_request(MODE_SET_STATE, 20'd0, 3'd7, 8'h00, 8'h00, 8'h00));
        push_request(make_request(MODE_SET_STATE, 20'd0, ST_OFF, 8'h00, 8'h00, 8'h00));
        push_request(make_request(MODE_SET_COLOUR, 20'd0, ST_OFF, 8'hAA, 8'h55, 8'h0F));
        push_request(make_request(MODE_SET_STATE, 20'hFFFFF, ST_CHARGING, 8'h55, 8'hAA, 8'hF0));

        // Random requests; ignored ones do not count toward the total.
        counted = 0;
        while (counted < RANDOM_REQUESTS)
        begin
            no_idle = (counted >= 300 && counted < 400) || (counted >= 800 && counted < 880);
            if (counted == 550)
            begin
                // Hold off new requests until the block has delivered everything.
                in_valid <= 1'b0;
                @(posedge clk);
                wait_frames_drained();
            end
            rq = random_request();
            push_request(rq);
            if (!(rq.mode == MODE_UNUSED ||
                  (rq.mode == MODE_SET_STATE && rq.new_state > ST_ALERT)))
            begin
                counted++;
            end
        end
        no_idle = 1'b0;

        in_valid <= 1'b0;
        @(posedge clk);
        wait_frames_drained();
        repeat (12) @(posedge clk);
        if (board.fails == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/slad_pkg.sv
rtl/slad_colour.sv
rtl/slad_outreg.sv
rtl/slad_core.sv
rtl/status_led_animator.sv
test/tb_status_led_animator.sv
